/* hdl/plus_minus_paren_expression_evaluator_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the expression evaluator
// Shared concurrent assertion forms used by the port monitor.
// ----------------------------------------------------------------------------
`ifndef PLUS_MINUS_PAREN_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define PLUS_MINUS_PAREN_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

// Assertion that is switched off while reset is high.
`define PMPE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("expression evaluator assertion failed");

// Assertion that is checked during reset as well.
`define PMPE_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("expression evaluator assertion failed");

`endif

/* hdl/pmpe_pkg.sv */
// ----------------------------------------------------------------------------
// pmpe_pkg
// Types, character codes and defaults shared by the expression evaluator.
// ----------------------------------------------------------------------------
package pmpe_pkg;

   // Width of the running sum, the current number and the saved sums.
   localparam int SUM_WIDTH = 64;
   localparam int VALUE_WIDTH = 32;

   // Default number of stack levels.
   localparam int NEST_DEPTH_DEFAULT = 16;

   // ASCII codes the evaluator reacts to.
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;

   // One input word: a character and the end-of-expression mark.
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_word_type;

   // One result word.
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          nest_overflow;
   } rsp_word_type;

   // One stack entry: the sign and sum of the enclosing level.
   typedef struct packed {
      logic                 sign;
      logic [SUM_WIDTH-1:0] sum;
   } stack_entry_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_RUN,
      ST_LOAD,
      ST_CLOSE
   } state_type;

endpackage

/* hdl/plus_minus_paren_expression_evaluator_top.sv */
// ----------------------------------------------------------------------------
// plus_minus_paren_expression_evaluator_top
// Evaluates an ASCII expression of integers, '+', '-' and parentheses.
// ----------------------------------------------------------------------------
// Characters enter one per cycle on the req_ channel while req_stall is low;
// the word marked last ends the expression and causes one result word on
// the rsp_ channel. A ')' that closes an open level stalls the channel in
// ST_LOAD, because the enclosing sum and sign come back from the stack RAM
// in the cycle after the read is issued and the next character needs them.
// After the last word, each level still open is closed through the same
// read of the stack RAM, by way of ST_CLOSE and ST_LOAD, before the result
// is written and the next word is taken. The block waits in ST_CLOSE longer
// only while an earlier result is still held on rsp_. New characters are
// taken while a result waits. The stack needs no clearing after reset, so
// the block is ready at once.
module plus_minus_paren_expression_evaluator_top #(
   parameter int NEST_DEPTH = pmpe_pkg::NEST_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pmpe_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pmpe_pkg::rsp_word_type rsp_word
);

   localparam int LEVEL_WIDTH = $clog2(NEST_DEPTH + 1);
   localparam int ADDR_WIDTH = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam int SW = pmpe_pkg::SUM_WIDTH;

   pmpe_pkg::state_type      state_ff, state_in;
   logic [LEVEL_WIDTH-1:0]   level_ff, level_in, level_dec;
   logic [SW-1:0]            running_sum_ff, running_sum_in;
   logic [SW-1:0]            current_ff, current_in;
   logic                     negative_ff, negative_in;
   logic                     finished_ff, finished_in;
   logic                     overflowed_ff, overflowed_in;
   logic                     ending_ff, ending_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   pmpe_pkg::rsp_word_type   rsp_word_ff, rsp_word_in;

   logic [SW-1:0]            folded;
   logic [SW-1:0]            times_ten;
   logic [SW-1:0]            digit;
   logic                     ram_wr_en, ram_rd_en;
   pmpe_pkg::stack_entry_type ram_wr_entry, ram_rd_entry;
   logic [$bits(pmpe_pkg::stack_entry_type)-1:0] ram_rd_data;

   // Stack of enclosing sums and signs, one entry per open level.
   pmpe_ram #(
      .WIDTH      ($bits(pmpe_pkg::stack_entry_type)),
      .DEPTH      (NEST_DEPTH),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (level_ff[ADDR_WIDTH-1:0]),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (level_dec[ADDR_WIDTH-1:0]),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_entry = pmpe_pkg::stack_entry_type'(ram_rd_data);
   assign ram_wr_entry = '{sign: negative_ff, sum: running_sum_ff};
   assign level_dec = LEVEL_WIDTH'(level_ff - 1'b1);

   // Level value with the current number folded in, and the digit step.
   assign folded = negative_ff ? (running_sum_ff - current_ff)
                               : (running_sum_ff + current_ff);
   assign digit = SW'(req_word.ch - pmpe_pkg::CH_ZERO);
   assign times_ten = {current_ff[SW-4:0], 3'b000} + {current_ff[SW-2:0], 1'b0};

   // Next state, register updates and RAM control.
   always_comb begin
      state_in       = state_ff;
      level_in       = level_ff;
      running_sum_in = running_sum_ff;
      current_in     = current_ff;
      negative_in    = negative_ff;
      finished_in    = finished_ff;
      overflowed_in  = overflowed_ff;
      ending_in      = ending_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_word_in    = rsp_word_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      req_stall      = 1'b1;

      case (state_ff)
         pmpe_pkg::ST_RUN: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (!finished_ff) begin
                  if (req_word.ch >= pmpe_pkg::CH_ZERO &&
                      req_word.ch <= pmpe_pkg::CH_NINE) begin
                     current_in = times_ten + digit;
                  end else if (req_word.ch == pmpe_pkg::CH_PLUS ||
                               req_word.ch == pmpe_pkg::CH_MINUS) begin
                     running_sum_in = folded;
                     current_in     = '0;
                     negative_in    = (req_word.ch == pmpe_pkg::CH_MINUS);
                  end else if (req_word.ch == pmpe_pkg::CH_OPEN) begin
                     if (level_ff < LEVEL_WIDTH'(NEST_DEPTH)) begin
                        ram_wr_en      = 1'b1;
                        level_in       = LEVEL_WIDTH'(level_ff + 1'b1);
                        running_sum_in = '0;
                        current_in     = '0;
                        negative_in    = 1'b0;
                     end else begin
                        overflowed_in = 1'b1;
                     end
                  end else if (req_word.ch == pmpe_pkg::CH_CLOSE) begin
                     if (level_ff != '0) begin
                        // Pop: the enclosing sum and sign arrive next cycle.
                        ram_rd_en  = 1'b1;
                        current_in = folded;
                        level_in   = level_dec;
                        ending_in  = req_word.last;
                        state_in   = pmpe_pkg::ST_LOAD;
                     end else begin
                        // Unmatched close: keep the value, ignore the rest.
                        running_sum_in = folded;
                        current_in     = '0;
                        negative_in    = 1'b0;
                        finished_in    = 1'b1;
                     end
                  end
               end
               if (req_word.last && state_in == pmpe_pkg::ST_RUN) begin
                  state_in = pmpe_pkg::ST_CLOSE;
               end
            end
         end

         pmpe_pkg::ST_LOAD: begin
            running_sum_in = ram_rd_entry.sum;
            negative_in    = ram_rd_entry.sign;
            state_in       = ending_ff ? pmpe_pkg::ST_CLOSE : pmpe_pkg::ST_RUN;
         end

         pmpe_pkg::ST_CLOSE: begin
            if (level_ff != '0) begin
               // Implicit close of a level left open at the end.
               ram_rd_en  = 1'b1;
               current_in = folded;
               level_in   = level_dec;
               ending_in  = 1'b1;
               state_in   = pmpe_pkg::ST_LOAD;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_word_in.value         = folded[pmpe_pkg::VALUE_WIDTH-1:0];
               rsp_word_in.nest_overflow = overflowed_ff;
               running_sum_in            = '0;
               current_in                = '0;
               negative_in               = 1'b0;
               finished_in               = 1'b0;
               overflowed_in             = 1'b0;
               ending_in                 = 1'b0;
               state_in                  = pmpe_pkg::ST_RUN;
            end
         end

         default: begin
            state_in = pmpe_pkg::ST_RUN;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pmpe_pkg::ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   // Level state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff       <= '0;
         running_sum_ff <= '0;
         current_ff     <= '0;
         negative_ff    <= 1'b0;
         finished_ff    <= 1'b0;
         overflowed_ff  <= 1'b0;
         ending_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         level_ff       <= level_in;
         running_sum_ff <= running_sum_in;
         current_ff     <= current_in;
         negative_ff    <= negative_in;
         finished_ff    <= finished_in;
         overflowed_ff  <= overflowed_in;
         ending_ff      <= ending_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* hdl/pmpe_ram.sv */
// ----------------------------------------------------------------------------
// pmpe_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module pmpe_ram #(
   parameter int WIDTH      = 8,
   parameter int DEPTH      = 16,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/pmpe_monitor.sv */
// ----------------------------------------------------------------------------
// pmpe_monitor
// Port-level assertions for the expression evaluator, bound to its top level.
// ----------------------------------------------------------------------------
`include "plus_minus_paren_expression_evaluator_top_defines.svh"

module pmpe_monitor (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input pmpe_pkg::req_word_type req_word,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input pmpe_pkg::rsp_word_type rsp_word
);

   logic req_take;
   logic rsp_hold;

   assign req_take = req_valid & ~req_stall;
   assign rsp_hold = rsp_valid & rsp_stall;

   // A held result word stays in place until it is taken.
   `PMPE_ASSERT(a_rsp_hold, clock, reset, rsp_hold |=> rsp_valid && $stable(rsp_word))

   // Reset empties the result register.
   `PMPE_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // A word that does not end the expression never produces a result.
   `PMPE_ASSERT(a_no_early_rsp, clock, reset,
      req_take && !req_word.last && !rsp_hold |=> !rsp_valid)

   // After the last word the block finishes the expression before taking more.
   `PMPE_ASSERT(a_last_stalls, clock, reset, req_take && req_word.last |=> req_stall)

endmodule

bind plus_minus_paren_expression_evaluator_top pmpe_monitor u_monitor (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
